// ===== hdl/cbc_pkg.sv =====
`timescale 1ns / 1ps

package cbc_pkg;

  // Sizes of the cartridge store and the ROM address space.
  localparam int RAM_BYTES        = 32768;
  localparam int RAM_AW           = $clog2(RAM_BYTES);
  localparam int ROM_ADDRESS_BITS = 21;

  // Fixed field widths of the bus and of the result.
  localparam int BUS_AW     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_ADDR_W = 21;
  localparam int BANK_W     = 7;
  localparam int RAM_BANK_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Width of a bank-plus-offset RAM index before wrapping to the store size.
  localparam int RAM_IDX_FULL_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_QUAD = 2'd2;

  // Mapper type codes.
  localparam logic [1:0] MAPPER_PLAIN = 2'd0;
  localparam logic [1:0] MAPPER_MBC1  = 2'd1;
  localparam logic [1:0] MAPPER_MBC3  = 2'd2;

  // Control register windows inside the ROM region, selected by address bits 14:13.
  localparam logic [1:0] WIN_RAM_ENABLE = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK   = 2'd1;
  localparam logic [1:0] WIN_UPPER_BANK = 2'd2;
  localparam logic [1:0] WIN_BANK_MODE  = 2'd3;

  // Address bits 15:13 of the external RAM window.
  localparam logic [2:0] RAM_REGION_TAG = 3'b101;

  // ROM size codes at which the bank count reaches 32 and 64.
  localparam logic [2:0] SIZE_CODE_32_BANKS = 3'd4;
  localparam logic [2:0] SIZE_CODE_64_BANKS = 3'd5;

  localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
  localparam logic [DATA_W-1:0] OPEN_BUS_VALUE = 8'hFF;
  localparam logic [BANK_W-1:0] LOW_MASK_64    = 7'h20;
  localparam logic [BANK_W-1:0] LOW_MASK_BIG   = 7'h60;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_ROM_READ = 2'd0,
    KIND_RAM_READ = 2'd1,
    KIND_WRITE    = 2'd2,
    KIND_OUTSIDE  = 2'd3
  } access_kind_t;

  // Configuration register file.
  typedef struct packed {
    logic [1:0] mapper_type;
    logic [2:0] rom_size_code;
    logic       ram_bank_quad;
  } cbc_cfg_t;

  // One access to the RAM store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [RAM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  // Decoded result of one transaction, before RAM data is merged in.
  typedef struct packed {
    access_kind_t          kind;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  use_ram;
    logic [DATA_W-1:0]     const_value;
  } cbc_result_t;

endpackage

// ===== hdl/cbc_if.sv =====
`timescale 1ns / 1ps

// Bus access channel.
interface cbc_in_if import cbc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BUS_AW-1:0] bus_address;
  logic [DATA_W-1:0] write_byte_value;

  modport source (output valid, output opcode, output bus_address,
                  output write_byte_value, input ready);
  modport sink   (input valid, input opcode, input bus_address,
                  input write_byte_value, output ready);
endinterface

// Result channel.
interface cbc_out_if import cbc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            access_kind;
  logic [ROM_ADDR_W-1:0] rom_address;
  logic [DATA_W-1:0]     read_value;

  modport source (output valid, output access_kind, output rom_address,
                  output read_value, input ready);
  modport sink   (input valid, input access_kind, input rom_address,
                  input read_value, output ready);
endinterface

// Configuration write channel.
interface cbc_cfg_if import cbc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cbc_ram_store.sv =====
`timescale 1ns / 1ps

module cbc_ram_store import cbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ram_req_t          req,
  output logic [DATA_W-1:0] rdata,
  output logic              busy
);

  logic [DATA_W-1:0] mem [RAM_BYTES];
  logic [DATA_W-1:0] rdata_r;
  logic              clearing_r;
  logic              clearing_nxt;
  logic [RAM_AW-1:0] clr_addr_r;
  logic [RAM_AW-1:0] clr_addr_nxt;

  // The clearing pass walks every entry once after reset.
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == RAM_AW'(RAM_BYTES - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Single port: clearing writes, transaction writes, or a registered read.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clearing_r;

endmodule

// ===== hdl/cbc_decode.sv =====
`timescale 1ns / 1ps

module cbc_decode import cbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_cfg_t          cfg,
  input  logic              accept,
  input  logic              opcode,
  input  logic [BUS_AW-1:0] bus_address,
  input  logic [DATA_W-1:0] write_byte_value,
  output ram_req_t          ram_req,
  output cbc_result_t       result
);

  logic [BANK_W-1:0]     rom_bank_r;
  logic [BANK_W-1:0]     rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r;
  logic [RAM_BANK_W-1:0] ram_bank_nxt;
  logic                  ram_enable_r;
  logic                  ram_enable_nxt;
  logic                  banking_mode_r;
  logic                  banking_mode_nxt;

  logic                      is_rom;
  logic                      is_ram;
  logic                      big_rom;
  logic                      rom_64;
  logic [4:0]                bank_mask;
  logic [BANK_W-1:0]         low_bank;
  logic [BANK_W-1:0]         read_bank;
  logic [RAM_BANK_W-1:0]     ram_bank_sel;
  logic [RAM_IDX_FULL_W-1:0] ram_idx_full;
  logic [ROM_ADDR_W-1:0]     rom_full;

  // Address regions and ROM size classes.
  assign is_rom  = !bus_address[BUS_AW-1];
  assign is_ram  = (bus_address[BUS_AW-1:13] == RAM_REGION_TAG);
  assign big_rom = (cfg.rom_size_code >= SIZE_CODE_64_BANKS);
  assign rom_64  = (cfg.rom_size_code == SIZE_CODE_64_BANKS);

  // Mask of the 5-bit bank write: bank count minus one, capped at 31.
  assign bank_mask = (cfg.rom_size_code >= SIZE_CODE_32_BANKS) ? 5'h1F
                     : 5'((5'd2 << cfg.rom_size_code[1:0]) - 5'd1);

  // Bank seen in the low ROM window under MBC1 banking mode 1.
  assign low_bank = (banking_mode_r && big_rom)
                    ? (rom_bank_r & (rom_64 ? LOW_MASK_64 : LOW_MASK_BIG)) : '0;

  assign read_bank = bus_address[14] ? rom_bank_r
                     : ((cfg.mapper_type == MAPPER_MBC1) ? low_bank : '0);

  // ROM byte address, wrapped to the ROM address space.
  assign rom_full = {read_bank, bus_address[13:0]};

  // MBC1 uses the RAM bank only in mode 1; the other mappers use it as is.
  assign ram_bank_sel = (cfg.mapper_type == MAPPER_MBC1 && !banking_mode_r)
                        ? '0 : ram_bank_r;
  assign ram_idx_full = {ram_bank_sel, bus_address[12:0]};

  // Register updates, RAM request and result of the current transaction.
  always_comb begin
    rom_bank_nxt       = rom_bank_r;
    ram_bank_nxt       = ram_bank_r;
    ram_enable_nxt     = ram_enable_r;
    banking_mode_nxt   = banking_mode_r;
    ram_req.we         = 1'b0;
    ram_req.re         = 1'b0;
    ram_req.addr       = RAM_AW'(ram_idx_full);
    ram_req.wdata      = write_byte_value;
    result.kind        = KIND_OUTSIDE;
    result.rom_address = '0;
    result.use_ram     = 1'b0;
    result.const_value = '0;

    if (is_rom || is_ram) begin
      if (opcode) begin
        result.kind = KIND_WRITE;
        case (cfg.mapper_type)
          MAPPER_MBC1: begin
            if (is_ram) begin
              ram_req.we = accept && ram_enable_r;
            end else begin
              unique case (bus_address[14:13])
                WIN_RAM_ENABLE: begin
                  ram_enable_nxt = (write_byte_value[3:0] == RAM_ENABLE_KEY);
                end
                WIN_ROM_BANK: begin
                  rom_bank_nxt = (write_byte_value[4:0] == 5'd0) ? BANK_W'(1)
                                 : {2'b00, write_byte_value[4:0] & bank_mask};
                end
                WIN_UPPER_BANK: begin
                  if (banking_mode_r) begin
                    if (cfg.ram_bank_quad) begin
                      ram_bank_nxt = write_byte_value[1:0];
                    end
                    if (big_rom) begin
                      rom_bank_nxt = {write_byte_value[1:0], rom_bank_r[4:0]};
                      if (rom_64) begin
                        rom_bank_nxt[6] = 1'b0;
                      end
                    end
                  end
                end
                WIN_BANK_MODE: begin
                  banking_mode_nxt = write_byte_value[0];
                end
                default: begin
                end
              endcase
            end
          end
          MAPPER_MBC3: begin
            if (is_ram) begin
              ram_req.we = accept && ram_enable_r;
            end else if (bus_address[14:13] == WIN_RAM_ENABLE) begin
              ram_enable_nxt = (write_byte_value[3:0] == RAM_ENABLE_KEY);
            end else if (bus_address[14:13] == WIN_ROM_BANK) begin
              rom_bank_nxt = (write_byte_value[6:0] == 7'd0) ? BANK_W'(1)
                             : write_byte_value[6:0];
            end
          end
          default: begin
          end
        endcase
      end else if (is_rom) begin
        result.kind        = KIND_ROM_READ;
        result.rom_address = ROM_ADDR_W'(ROM_ADDRESS_BITS'(rom_full));
      end else begin
        result.kind = KIND_RAM_READ;
        // Plain ROM reads the store regardless of the enable.
        if (ram_enable_r || (cfg.mapper_type != MAPPER_MBC1 &&
                             cfg.mapper_type != MAPPER_MBC3)) begin
          result.use_ram = 1'b1;
          ram_req.re     = accept;
        end else begin
          result.const_value = OPEN_BUS_VALUE;
        end
      end
    end
  end

  // Bank control registers change only when a transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r     <= BANK_W'(1);
      ram_bank_r     <= '0;
      ram_enable_r   <= 1'b0;
      banking_mode_r <= 1'b0;
    end else if (accept) begin
      rom_bank_r     <= rom_bank_nxt;
      ram_bank_r     <= ram_bank_nxt;
      ram_enable_r   <= ram_enable_nxt;
      banking_mode_r <= banking_mode_nxt;
    end
  end

endmodule

// ===== hdl/cartridge_bank_controller_core.sv =====
`timescale 1ns / 1ps

// Cartridge bank controller: takes one CPU bus access per cycle unless stalled
// and answers it as plain ROM, MBC1 or MBC3 mapper, giving a ROM byte address,
// a RAM byte (or 0xFF with RAM disabled), a write acknowledge or an
// outside-cartridge mark. Throughput is one transaction per clock when the input
// does not stall; each transaction is decoded into a stage register that also
// catches the RAM read data, then moves to the output register. While a finished
// result waits in the output register, the stage register can take one more
// transaction and the input then stalls until the result is taken. The
// single-port 32 KiB battery RAM is cleared after reset by a pass over every
// byte, one byte per cycle, during which in_ch.ready stays low.
// Configuration writes are always taken and must only be issued while idle.
module cartridge_bank_controller_core import cbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cbc_in_if.sink    in_ch,
  cbc_out_if.source out_ch,
  cbc_cfg_if.sink   cfg_ch
);

  cbc_cfg_t    cfg_r;
  ram_req_t    ram_req;
  cbc_result_t dec_result;
  logic [DATA_W-1:0] ram_rdata;
  logic        ram_busy;
  logic        in_accept;
  logic        s1_move;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  access_kind_t          s1_kind_r;
  logic [ROM_ADDR_W-1:0] s1_rom_addr_r;
  logic                  s1_use_ram_r;
  logic [DATA_W-1:0]     s1_const_r;

  logic                  out_valid_r;
  access_kind_t          out_kind_r;
  logic [ROM_ADDR_W-1:0] out_rom_addr_r;
  logic [DATA_W-1:0]     out_value_r;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAPPER_TYPE:   cfg_r.mapper_type   <= cfg_ch.data[1:0];
        CFG_ROM_SIZE_CODE: cfg_r.rom_size_code <= cfg_ch.data;
        CFG_RAM_BANK_QUAD: cfg_r.ram_bank_quad <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the stage register drains whenever the output register is free.
  assign s1_move      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !ram_busy && (!s1_valid_r || s1_move);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_move);

  cbc_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .accept           (in_accept),
    .opcode           (in_ch.opcode),
    .bus_address      (in_ch.bus_address),
    .write_byte_value (in_ch.write_byte_value),
    .ram_req          (ram_req),
    .result           (dec_result)
  );

  cbc_ram_store u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata),
    .busy  (ram_busy)
  );

  // Stage register, aligned with the registered RAM read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r     <= dec_result.kind;
      s1_rom_addr_r <= dec_result.rom_address;
      s1_use_ram_r  <= dec_result.use_ram;
      s1_const_r    <= dec_result.const_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_kind_r     <= s1_kind_r;
      out_rom_addr_r <= s1_rom_addr_r;
      out_value_r    <= s1_use_ram_r ? ram_rdata : s1_const_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.access_kind = out_kind_r;
  assign out_ch.rom_address = out_rom_addr_r;
  assign out_ch.read_value  = out_value_r;

  // A stalled stage register keeps its transaction.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=>
      (s1_valid_r && $stable(s1_kind_r) && $stable(s1_rom_addr_r)))
    else $error("stage register lost a stalled transaction");

  // Only ROM reads carry a ROM address.
  a_rom_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_ROM_READ) |-> (out_rom_addr_r == '0))
    else $error("non-ROM result with a ROM address");

  // Only RAM reads carry a read value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_RAM_READ) |-> (out_value_r == '0))
    else $error("non-RAM result with a read value");

  // A new result comes only from a filled stage register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a transaction");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cbc_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  // Mapper code that has no mapper of its own; it must act as plain ROM.
  localparam logic [1:0] MAPPER_UNUSED = 2'd3;
  localparam int IDLE_LIMIT     = 200000;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PHASE = 94;

  // One bus access as the CPU issues it.
  typedef struct {
    logic              op;
    logic [BUS_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_access_t;

  // One response as the block should return it.
  typedef struct {
    access_kind_t          kind;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [DATA_W-1:0]     read_value;
  } bus_response_t;

  // Shadow of the mapper state plus the queue of responses still to come.
  class cartridge_model;
    logic [1:0]        mapper;
    logic [2:0]        size_code;
    logic              quad_ram;
    logic [BANK_W-1:0] rom_bank;
    logic [1:0]        ram_bank;
    logic              ram_on;
    logic              mode_one;
    logic [DATA_W-1:0] battery_ram [RAM_BYTES];
    bus_response_t     awaited[$];
    int                mismatches;
    int                kind_seen [4];
    int                register_writes;

    function new();
      mapper = MAPPER_PLAIN;
      size_code = '0;
      quad_ram = 1'b0;
      rom_bank = 7'd1;
      ram_bank = '0;
      ram_on = 1'b0;
      mode_one = 1'b0;
      mismatches = 0;
      register_writes = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      foreach (battery_ram[i]) battery_ram[i] = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      register_writes++;
      case (idx)
        CFG_MAPPER_TYPE:   mapper = val[1:0];
        CFG_ROM_SIZE_CODE: size_code = val;
        CFG_RAM_BANK_QUAD: quad_ram = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned bank_total();
      return 32'd2 << size_code;
    endfunction

    // Byte offset into the battery store for a RAM-window address.
    function int unsigned store_index(logic [1:0] bank, logic [BUS_AW-1:0] addr);
      int unsigned idx;
      idx = (int'(addr) - 32'hA000) + 32'h2000 * bank;
      return idx % RAM_BYTES;
    endfunction

    function logic [ROM_ADDR_W-1:0] rom_byte(int unsigned bank, int unsigned offset);
      int unsigned full;
      full = offset + 32'h4000 * bank;
      full = full & ((32'd1 << ROM_ADDRESS_BITS) - 1);
      return full[ROM_ADDR_W-1:0];
    endfunction

    // Bank that MBC1 maps into 0x0000-0x3FFF.
    function int unsigned mbc1_low_bank();
      int unsigned banks;
      banks = bank_total();
      if (mode_one && banks > 32)
        return rom_bank & (banks == 64 ? LOW_MASK_64 : LOW_MASK_BIG);
      return 0;
    endfunction

    function void mbc1_ctrl_write(logic [BUS_AW-1:0] addr, logic [DATA_W-1:0] data);
      int unsigned banks;
      int unsigned mask;
      banks = bank_total();
      if (addr[15] == 1'b0) begin
        case (addr[14:13])
          WIN_RAM_ENABLE: ram_on = (data[3:0] == RAM_ENABLE_KEY);
          WIN_ROM_BANK: begin
            mask = (banks >= 32) ? 31 : banks - 1;
            if (data[4:0] == 5'd0) rom_bank = 7'd1;
            else rom_bank = 7'(data & mask);
          end
          WIN_UPPER_BANK: begin
            if (mode_one) begin
              if (quad_ram) ram_bank = data[1:0];
              if (banks > 32) begin
                rom_bank = (rom_bank & 7'h1F) | {data[1:0], 5'd0};
                if (banks == 64) rom_bank[6] = 1'b0;
              end
            end
          end
          default: mode_one = data[0];
        endcase
      end else if (ram_on) begin
        battery_ram[store_index(mode_one ? ram_bank : 2'd0, addr)] = data;
      end
    endfunction

    function void mbc3_ctrl_write(logic [BUS_AW-1:0] addr, logic [DATA_W-1:0] data);
      if (addr[15] == 1'b0) begin
        case (addr[14:13])
          WIN_RAM_ENABLE: ram_on = (data[3:0] == RAM_ENABLE_KEY);
          WIN_ROM_BANK: rom_bank = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
          // The RAM bank and clock registers are not modeled.
          default: ;
        endcase
      end else if (ram_on) begin
        battery_ram[store_index(ram_bank, addr)] = data;
      end
    endfunction

    // Apply one accepted bus transaction and queue the response it must produce.
    function void note_access(bus_access_t a);
      bus_response_t r;
      logic is_rom;
      logic is_ram;
      r.kind = KIND_OUTSIDE;
      r.rom_address = '0;
      r.read_value = '0;
      is_rom = (a.addr[15] == 1'b0);
      is_ram = (a.addr[15:13] == RAM_REGION_TAG);
      if (is_rom || is_ram) begin
        if (a.op == OP_WRITE) begin
          r.kind = KIND_WRITE;
          if (mapper == MAPPER_MBC1) mbc1_ctrl_write(a.addr, a.data);
          else if (mapper == MAPPER_MBC3) mbc3_ctrl_write(a.addr, a.data);
        end else if (is_rom) begin
          r.kind = KIND_ROM_READ;
          if (a.addr[14] == 1'b0)
            r.rom_address = rom_byte(mapper == MAPPER_MBC1 ? mbc1_low_bank() : 0,
                                     a.addr);
          else
            r.rom_address = rom_byte(rom_bank, a.addr - 16'h4000);
        end else begin
          r.kind = KIND_RAM_READ;
          if (mapper == MAPPER_MBC1)
            r.read_value = ram_on ? battery_ram[store_index(mode_one ? ram_bank : 2'd0,
                                                            a.addr)] : OPEN_BUS_VALUE;
          else if (mapper == MAPPER_MBC3)
            r.read_value = ram_on ? battery_ram[store_index(ram_bank, a.addr)]
                                  : OPEN_BUS_VALUE;
          else
            r.read_value = battery_ram[store_index(ram_bank, a.addr)];
        end
      end
      awaited.push_back(r);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one returned response with the oldest one still awaited.
    task check_response(logic [1:0] kind, logic [ROM_ADDR_W-1:0] addr,
                        logic [DATA_W-1:0] value);
      bus_response_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("response kind %0d arrived with nothing outstanding", kind));
        return;
      end
      exp = awaited.pop_front();
      kind_seen[exp.kind]++;
      if (kind !== exp.kind)
        report($sformatf("access_kind got %0d expected %0d", kind, exp.kind));
      if (addr !== exp.rom_address)
        report($sformatf("rom_address got %h expected %h", addr, exp.rom_address));
      if (value !== exp.read_value)
        report($sformatf("read_value got %h expected %h", value, exp.read_value));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic steady;
  int   sent;
  cartridge_model model;

  cbc_in_if  in_ch ();
  cbc_out_if out_ch ();
  cbc_cfg_if cfg_ch ();

  cartridge_bank_controller_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random bus transaction, weighted toward the windows that carry behavior.
  function automatic bus_access_t random_access();
    bus_access_t a;
    int pick;
    logic [12:0] offset;
    pick = $urandom_range(0, 99);
    a.op = OP_READ;
    a.data = 8'($urandom_range(0, 255));
    if (pick < 28) begin
      a.addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 52) begin
      a.op = OP_WRITE;
      a.addr = 16'($urandom_range(0, 16'h7FFF));
      if (a.addr[14:13] == WIN_RAM_ENABLE && $urandom_range(0, 1))
        a.data[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 82) begin
      // Keep many RAM accesses on a few bytes so reads find earlier writes.
      a.op = 1'($urandom_range(0, 1));
      offset = 13'($urandom_range(0, 13'h1FFF));
      if ($urandom_range(0, 1)) offset = {$urandom_range(0, 1) ? 9'h1FF : 9'h000,
                                          4'($urandom_range(0, 15))};
      a.addr = {RAM_REGION_TAG, offset};
    end else if (pick < 92) begin
      a.op = 1'($urandom_range(0, 1));
      a.addr = 16'($urandom_range(0, 1) ? $urandom_range(16'h8000, 16'h9FFF)
                                        : $urandom_range(16'hC000, 16'hFFFF));
    end else begin
      a.op = 1'($urandom_range(0, 1));
      a.addr = 16'($urandom_range(0, 16'hFFFF));
    end
    return a;
  endfunction

  // Offer one bus transaction and hold it until the block takes it.
  task automatic send_access(logic op, logic [BUS_AW-1:0] addr, logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.bus_address <= addr;
    in_ch.write_byte_value <= data;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Stop sending and wait until every queued response has been returned.
  task automatic drain_responses();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program all three configuration registers back to back.
  task automatic apply_settings(logic [1:0] mapper, logic [2:0] code, logic four);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_MAPPER_TYPE, CFG_ROM_SIZE_CODE, CFG_RAM_BANK_QUAD};
    val = '{CFG_DATA_W'(mapper), code, CFG_DATA_W'(four)};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Result-side backpressure: random stalls between runs of ready.
  initial begin : response_stall
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Track every transaction on the three channels.
  always @(posedge clk) begin : channel_monitor
    bus_access_t a;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        model.write_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        a.op = in_ch.opcode;
        a.addr = in_ch.bus_address;
        a.data = in_ch.write_byte_value;
        model.note_access(a);
      end
      if (out_ch.valid && out_ch.ready)
        model.check_response(out_ch.access_kind, out_ch.rom_address, out_ch.read_value);
    end
  end

  // Give up when no transaction of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bus_access_t a;
    logic [1:0]  map_sel [8];
    logic [2:0]  code_sel [8];
    logic        four_sel [8];
    model = new();
    steady = 1'b0;
    sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_READ;
    in_ch.bus_address <= '0;
    in_ch.write_byte_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MAPPER_TYPE;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on MBC1 with 64 ROM banks and four RAM banks.
    apply_settings(MAPPER_MBC1, SIZE_CODE_64_BANKS, 1'b1);
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_READ, 16'h3FFF, 8'hFF);
    send_access(OP_READ, 16'h4000, 8'h00);
    send_access(OP_READ, 16'h7FFF, 8'h00);
    // RAM is still disabled, so the open-bus value comes back.
    send_access(OP_READ, 16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h0000, 8'h0A);
    send_access(OP_WRITE, 16'hA000, 8'hFF);
    send_access(OP_WRITE, 16'hBFFF, 8'h5A);
    send_access(OP_READ, 16'hA000, 8'h00);
    send_access(OP_READ, 16'hBFFF, 8'h00);
    // A zero bank number selects bank 1; the largest value is masked.
    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFF);
    // In banking mode 1 the upper bits land in the bank; bit 6 clears at 64 banks.
    send_access(OP_WRITE, 16'h6000, 8'h01);
    send_access(OP_WRITE, 16'h5FFF, 8'h03);
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_READ, 16'h7FFF, 8'h00);
    send_access(OP_READ, 16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h20);
    send_access(OP_WRITE, 16'h7FFF, 8'h00);
    // Accesses outside the cartridge windows, then a RAM disable and a RAM read.
    send_access(OP_READ, 16'h8000, 8'h00);
    send_access(OP_WRITE, 16'h9FFF, 8'hAA);
    send_access(OP_READ, 16'hC000, 8'h00);
    send_access(OP_WRITE, 16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'h1FFF, 8'h00);
    send_access(OP_READ, 16'hBFFF, 8'h00);

    // Random phases; the first ones walk through the extreme settings.
    map_sel  = '{MAPPER_MBC1, MAPPER_MBC1, MAPPER_MBC1, MAPPER_MBC1,
                 MAPPER_MBC3, MAPPER_PLAIN, MAPPER_UNUSED, MAPPER_MBC3};
    code_sel = '{3'd0, 3'd7, SIZE_CODE_64_BANKS, 3'd6, 3'd6, 3'd0, SIZE_CODE_32_BANKS, 3'd7};
    four_sel = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < PHASES; p++) begin
      drain_responses();
      if (p < 8)
        apply_settings(map_sel[p], code_sel[p], four_sel[p]);
      else
        apply_settings(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
      steady = (p % 4 == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        a = random_access();
        send_access(a.op, a.addr, a.data);
      end
    end
    steady = 1'b0;
    drain_responses();

    $display("Sent %0d bus transactions across %0d configuration writes.",
             sent, model.register_writes);
    $display("Responses: %0d ROM reads, %0d RAM reads, %0d writes, %0d outside, %0d errors.",
             model.kind_seen[KIND_ROM_READ], model.kind_seen[KIND_RAM_READ],
             model.kind_seen[KIND_WRITE], model.kind_seen[KIND_OUTSIDE], model.mismatches);
    if (model.mismatches == 0 && model.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
